FILE: rtl/core/lfdcs_pkg.sv
// Shared types, constants and helpers of the LED flash digit-code sequencer.
package lfdcs_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int MAX_DIGITS  = 8;
  localparam int CODE_DIGITS = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;
  localparam int DIG_IDX_W   = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int DIG_CNT_W   = $clog2(CODE_DIGITS + 1);

  localparam int TICK_W      = 16;
  localparam int STEP_W      = TICK_W + 1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  typedef struct packed {
    logic              level;
    logic [TICK_W-1:0] ticks;
  } step_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PIN_DIGITS   = 8'd0,
    CFG_PIN_LENGTH   = 8'd1,
    CFG_KEEP_ALIVE   = 8'd2,
    CFG_FLASH        = 8'd3,
    CFG_SHORT_PULSE  = 8'd4,
    CFG_GAP          = 8'd5,
    CFG_RESEND       = 8'd6,
    CFG_FORCE_WAIT   = 8'd7
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRANS,
    S_POP,
    S_KA,
    S_FLASH,
    S_FORCE,
    S_PRE,
    S_DIGIT,
    S_PULSE,
    S_DGAP,
    S_DONE
  } state_t;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] t);
    return (t == '0) ? TICK_W'(1) : t;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

FILE: rtl/core/lfdcs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lfdcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/led_flash_digit_code_sequencer.sv
// LED flash digit-code sequencer: tick-driven LED step queue with code expansion.
//
// Each input transaction on the s_ group is one timer tick; s_tdata[0] is the
// button level. For every tick exactly one result transaction leaves on the
// m_ group carrying the LED level and the ticks left in the current step.
// The step queue lives in one synchronous RAM; each tick reads at most one
// step from it, and a refill writes at most one step per cycle into it.
// A tick whose step does not end passes from S_IDLE through S_DONE to the
// result; a pop passes S_TRANS and S_POP, a keep-alive refill S_TRANS, S_KA
// and S_FLASH, and a code refill writes the force wait and, for a non-empty
// code, the preamble, digit pulses and gaps into the queue, one step at a time.
// One tick is in work at a time; s_tready is high while the block waits for a
// tick, also while a result is still held.
// If the receiver stalls, the finished result stays in the output register
// and the next tick finishes only once that result has been taken.
// Configuration writes on the cfg_ group are always accepted and must only be
// issued while no tick is in work. Reset empties the queue, clears the wait
// and keep-alive counters, turns the LED off and loads the default
// configuration; the queue RAM needs no clearing, as only written entries are read.
module led_flash_digit_code_sequencer
  import lfdcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] button_pressed
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] led_on, [16:1] wait_left
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  state_t state, state_next;

  logic [PTR_W-1:0]     rp, wp;
  logic [TICK_W-1:0]    wc;
  logic [7:0]           ka;
  logic                 led;
  logic [DIG_CNT_W-1:0] code_len;
  logic [DIG_IDX_W-1:0] dig_idx;
  logic [3:0]           digit;
  logic [3:0]           pulse_cnt;
  logic                 phase;
  logic [1:0]           pre_cnt;

  logic [31:0]          pin_digits;
  logic [3:0]           pin_length;
  logic [TICK_W-1:0]    ka_off_len;
  logic [TICK_W-1:0]    ka_on_len;
  logic [TICK_W-1:0]    pulse_len;
  logic [23:0]          gap_ticks;
  logic [7:0]           resend_period;
  logic [TICK_W-1:0]    force_wait_ticks;

  logic                 accept;
  logic                 button;
  logic                 out_free;
  logic                 queue_empty;
  logic [DIG_CNT_W-1:0] len_calc;
  logic [31:0]          digits_shifted;
  logic [3:0]           cur_nibble;

  logic                 push_req;
  logic                 push_we;
  step_t                push_step;
  logic [TICK_W-1:0]    push_ticks_raw;
  logic [PTR_W-1:0]     push_addr;
  logic [PTR_W-1:0]     rp_cmp;
  logic                 rd_en;
  step_t                rd_step;

  assign accept      = s_tvalid && s_tready;
  assign button      = s_tdata[0];
  assign s_tready    = (state == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_free    = !m_tvalid || m_tready;
  assign queue_empty = (rp == wp);

  assign len_calc = (pin_length > 4'(CODE_DIGITS)) ? DIG_CNT_W'(CODE_DIGITS)
                                                   : DIG_CNT_W'(pin_length);
  assign digits_shifted = pin_digits >> {dig_idx, 2'b00};
  assign cur_nibble     = digits_shifted[3:0];

  lfdcs_ram #(
    .WIDTH(STEP_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .wr_en  (push_we),
    .wr_addr(push_addr),
    .wr_data(push_step),
    .rd_en  (rd_en),
    .rd_addr(rp),
    .rd_data(rd_step)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (button || wc[TICK_W-1:1] == '0) ? S_TRANS : S_DONE;
        end
      end
      S_TRANS: begin
        if (!queue_empty) begin
          state_next = S_POP;
        end else if (ka < resend_period) begin
          state_next = S_KA;
        end else begin
          state_next = S_FORCE;
        end
      end
      S_POP:   state_next = S_DONE;
      S_KA:    state_next = S_FLASH;
      S_FLASH: state_next = S_DONE;
      S_FORCE: state_next = (len_calc == '0) ? S_DONE : S_PRE;
      S_PRE: begin
        if (pre_cnt == 2'd3) begin
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (cur_nibble > 4'd9) begin
          state_next = S_DONE;
        end else if (cur_nibble == 4'd0) begin
          state_next = S_DGAP;
        end else begin
          state_next = S_PULSE;
        end
      end
      S_PULSE: begin
        if (phase && (pulse_cnt + 4'd1 == digit)) begin
          state_next = S_DGAP;
        end
      end
      S_DGAP: begin
        if (DIG_CNT_W'(dig_idx) + DIG_CNT_W'(1) == code_len) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIGIT;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    push_req         = 1'b0;
    push_step.level  = 1'b0;
    push_ticks_raw   = pulse_len;
    rd_en            = 1'b0;
    unique case (state) inside
      S_IDLE: begin
        push_req        = accept && button;
        push_step.level = 1'b1;
      end
      S_TRANS: begin
        rd_en = !queue_empty;
      end
      S_KA: begin
        push_req       = 1'b1;
        push_ticks_raw = ka_off_len;
      end
      S_FLASH: begin
        push_req        = 1'b1;
        push_step.level = 1'b1;
        push_ticks_raw  = ka_on_len;
      end
      S_FORCE: begin
        push_req       = 1'b1;
        push_ticks_raw = force_wait_ticks;
      end
      S_PRE: begin
        push_req        = 1'b1;
        push_step.level = !pre_cnt[0];
        push_ticks_raw  = pre_cnt[0] ? TICK_W'(gap_ticks[7:0]) : pulse_len;
      end
      S_PULSE: begin
        push_req        = 1'b1;
        push_step.level = !phase;
        push_ticks_raw  = phase ? TICK_W'(gap_ticks[15:8]) : pulse_len;
      end
      S_DGAP: begin
        push_req       = 1'b1;
        push_ticks_raw = TICK_W'(gap_ticks[23:16]);
      end
      S_POP, S_DIGIT, S_DONE: begin
      end
      default: begin
      end
    endcase
    push_step.ticks = at_least_one(push_ticks_raw);
    push_addr       = (state == S_IDLE) ? '0 : wp;
    rp_cmp          = (state == S_IDLE) ? '0 : rp;
    push_we         = push_req && (ptr_inc(push_addr) != rp_cmp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      rp               <= '0;
      wp               <= '0;
      wc               <= '0;
      ka               <= '0;
      led              <= 1'b0;
      m_tvalid         <= 1'b0;
      pin_digits       <= '0;
      pin_length       <= '0;
      ka_off_len       <= 16'd1000;
      ka_on_len        <= 16'd3;
      pulse_len        <= 16'd4;
      gap_ticks        <= 24'd2491146;
      resend_period    <= 8'd12;
      force_wait_ticks <= 16'd1300;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PIN_DIGITS:  pin_digits       <= cfg_data;
          CFG_PIN_LENGTH:  pin_length       <= cfg_data[3:0];
          CFG_KEEP_ALIVE:  ka_off_len       <= cfg_data[TICK_W-1:0];
          CFG_FLASH:       ka_on_len        <= cfg_data[TICK_W-1:0];
          CFG_SHORT_PULSE: pulse_len        <= cfg_data[TICK_W-1:0];
          CFG_GAP:         gap_ticks        <= cfg_data[23:0];
          CFG_RESEND:      resend_period    <= cfg_data[7:0];
          CFG_FORCE_WAIT:  force_wait_ticks <= cfg_data[TICK_W-1:0];
          default: begin
          end
        endcase
      end

      if (push_we) begin
        wp <= ptr_inc(push_addr);
      end

      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{(OUT_TDATA_W - STEP_W){1'b0}}, wc, led};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (button) begin
              rp <= '0;
              wc <= '0;
              ka <= '0;
              if (!push_we) begin
                wp <= '0;
              end
            end else if (wc != '0) begin
              wc <= wc - TICK_W'(1);
            end
          end
        end
        S_TRANS: begin
          if (queue_empty) begin
            ka <= (ka < resend_period) ? ka + 8'd1 : 8'd0;
          end
        end
        S_POP: begin
          led <= rd_step.level;
          wc  <= rd_step.ticks;
          rp  <= ptr_inc(rp);
        end
        S_FORCE: begin
          code_len <= len_calc;
          pre_cnt  <= 2'd0;
          dig_idx  <= '0;
        end
        S_PRE: begin
          pre_cnt <= pre_cnt + 2'd1;
        end
        S_DIGIT: begin
          digit     <= cur_nibble;
          pulse_cnt <= 4'd0;
          phase     <= 1'b0;
        end
        S_PULSE: begin
          phase <= !phase;
          if (phase) begin
            pulse_cnt <= pulse_cnt + 4'd1;
          end
        end
        S_DGAP: begin
          dig_idx <= dig_idx + DIG_IDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/lfdcs_checker.sv
// Port-level assertions for the LED flash digit-code sequencer and their bind.
module lfdcs_checker
  import lfdcs_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // Reset leaves no result pending and the block ready for a tick.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  // Only one tick is in work at a time.
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("tick accepted while another is in work");

  // A result never appears in the cycle right after its tick is taken.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind led_flash_digit_code_sequencer lfdcs_checker u_lfdcs_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

FILE: verif/led_flash_digit_code_sequencer_tb.sv
// Self-checking testbench of the LED flash digit-code sequencer with its own step-queue predictor.
`timescale 1ns / 100ps

module led_flash_digit_code_sequencer_tb;
  import lfdcs_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 8'd12;
  localparam int SEGMENTS          = 16;
  localparam int TICKS_PER_SEGMENT = 97;
  localparam int SETTLE_CYCLES     = 200;
  localparam int STALL_BURST       = 400;
  localparam int MAX_REPORTS       = 40;

  typedef struct packed {
    logic              led;
    logic [TICK_W-1:0] wait_left;
  } led_report_t;

  typedef enum logic { ROW_TICK, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    logic                   button;
    logic                   typed;
    led_report_t            report;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [0] button_pressed
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [0] led_on, [16:1] wait_left
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  led_flash_digit_code_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  led_report_t led_reports_due[$];
  int          error_count   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          burst_req     = 1'b0;

  step_t             step_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_m    = '0;
  logic [PTR_W-1:0]  tail_m    = '0;
  logic [TICK_W-1:0] wait_m    = '0;
  logic [7:0]        flashes_m = '0;
  logic              led_m     = 1'b0;

  logic [31:0] digits_r     = 32'd0;
  logic [3:0]  length_r     = 4'd0;
  logic [15:0] keep_alive_r = 16'd1000;
  logic [15:0] flash_r      = 16'd3;
  logic [15:0] pulse_r      = 16'd4;
  logic [23:0] gap_r        = 24'h26030A;
  logic [7:0]  resend_r     = 8'd12;
  logic [15:0] force_r      = 16'd1300;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic void push_step(input logic level, input logic [TICK_W-1:0] ticks);
    if (ring_next(tail_m) == head_m) return;
    step_mem[tail_m].level = level;
    step_mem[tail_m].ticks = (ticks == '0) ? TICK_W'(1) : ticks;
    tail_m = ring_next(tail_m);
  endfunction

  function automatic void push_code();
    int         len;
    logic [3:0] digit;
    len = (int'(length_r) > MAX_DIGITS) ? MAX_DIGITS : int'(length_r);
    if (len > 8) len = 8;
    if (len == 0) return;
    repeat (2) begin
      push_step(1'b1, pulse_r);
      push_step(1'b0, {8'd0, gap_r[7:0]});
    end
    for (int i = 0; i < len; i++) begin
      digit = digits_r[4*i +: 4];
      if (digit > 4'd9) break;
      repeat (digit) begin
        push_step(1'b1, pulse_r);
        push_step(1'b0, {8'd0, gap_r[15:8]});
      end
      push_step(1'b0, {8'd0, gap_r[23:16]});
    end
  endfunction

  function automatic led_report_t next_led_report(input logic button);
    bit    step_done;
    step_t popped;
    if (wait_m == '0) begin
      step_done = 1'b1;
    end else begin
      wait_m    = wait_m - 1'b1;
      step_done = (wait_m == '0);
    end
    if (button) begin
      head_m    = '0;
      tail_m    = '0;
      wait_m    = '0;
      flashes_m = '0;
      push_step(1'b1, pulse_r);
      step_done = 1'b1;
    end
    if (step_done) begin
      if (head_m != tail_m) begin
        popped = step_mem[head_m];
        head_m = ring_next(head_m);
        led_m  = popped.level;
        wait_m = popped.ticks;
      end else if (flashes_m < resend_r) begin
        flashes_m = flashes_m + 1'b1;
        push_step(1'b0, keep_alive_r);
        push_step(1'b1, flash_r);
      end else begin
        flashes_m = '0;
        push_step(1'b0, force_r);
        push_code();
      end
    end
    return '{led: led_m, wait_left: wait_m};
  endfunction

  function automatic void apply_cfg(input logic [CFG_INDEX_W-1:0] index,
                                    input logic [CFG_DATA_W-1:0] data);
    case (index)
      CFG_PIN_DIGITS:  digits_r     = data;
      CFG_PIN_LENGTH:  length_r     = data[3:0];
      CFG_KEEP_ALIVE:  keep_alive_r = data[15:0];
      CFG_FLASH:       flash_r      = data[15:0];
      CFG_SHORT_PULSE: pulse_r      = data[15:0];
      CFG_GAP:         gap_r        = data[23:0];
      CFG_RESEND:      resend_r     = data[7:0];
      CFG_FORCE_WAIT:  force_r      = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic stim_row_t tick_row(input logic button);
    return '{kind: ROW_TICK, index: '0, data: '0, button: button, typed: 1'b0, report: '0};
  endfunction

  function automatic stim_row_t checked_row(input logic button, input logic led,
                                            input logic [TICK_W-1:0] wait_left);
    return '{kind: ROW_TICK, index: '0, data: '0, button: button, typed: 1'b1,
             report: '{led: led, wait_left: wait_left}};
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_INDEX_W-1:0] index,
                                        input logic [CFG_DATA_W-1:0] data);
    return '{kind: ROW_CFG, index: index, data: data, button: 1'b0, typed: 1'b0, report: '0};
  endfunction

  task automatic send_tick(input logic button, input logic typed, input led_report_t typed_report);
    led_report_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, button};
    do @(posedge clk); while (!s_tready);
    predicted = next_led_report(button);
    led_reports_due.push_back(typed ? typed_report : predicted);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(index, data);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (led_reports_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: checks every transaction and keeps its own stall counter.
  initial begin
    int          hold_cycles;
    bit          burst_used;
    led_report_t got;
    led_report_t want;
    hold_cycles = 0;
    burst_used  = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = '{led: m_tdata[0], wait_left: m_tdata[TICK_W:1]};
        if (led_reports_due.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got led %0b wait_left %0d",
                     $time, got.led, got.wait_left);
        end else begin
          want = led_reports_due.pop_front();
          if (want.led != got.led) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: led_on mismatch, expected %0b, got %0b",
                       $time, want.led, got.led);
          end
          if (want.wait_left != got.wait_left) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: wait_left mismatch, expected %0d, got %0d",
                       $time, want.wait_left, got.wait_left);
          end
        end
      end
      if (burst_req && !burst_used) begin
        hold_cycles = STALL_BURST;
        burst_used  = 1'b1;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    stim_row_t             rows[$];
    stim_row_t             row;
    row_kind_t             prev_kind;
    logic [CFG_DATA_W-1:0] value;
    logic [CFG_DATA_W-1:0] top;
    int                    pick;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back(checked_row(1'b0, 1'b0, 16'd0));
    rows.push_back(checked_row(1'b0, 1'b0, 16'd1000));
    rows.push_back(checked_row(1'b0, 1'b0, 16'd999));
    rows.push_back(checked_row(1'b1, 1'b1, 16'd4));
    rows.push_back(checked_row(1'b0, 1'b1, 16'd3));
    rows.push_back(checked_row(1'b1, 1'b1, 16'd4));
    // Digits one and zero, then a digit above nine; every duration and gap is zero.
    rows.push_back(cfg_row(CFG_PIN_DIGITS, 32'hFFFF_FA01));
    rows.push_back(cfg_row(CFG_PIN_LENGTH, 32'd15));
    rows.push_back(cfg_row(CFG_RESEND, 32'd0));
    rows.push_back(cfg_row(CFG_FORCE_WAIT, 32'd0));
    rows.push_back(cfg_row(CFG_GAP, 32'd0));
    rows.push_back(cfg_row(CFG_SHORT_PULSE, 32'd0));
    rows.push_back(cfg_row(CFG_KEEP_ALIVE, 32'd0));
    rows.push_back(cfg_row(CFG_FLASH, 32'd0));
    rows.push_back(tick_row(1'b1));
    repeat (11) rows.push_back(tick_row(1'b0));
    rows.push_back(cfg_row(CFG_PIN_LENGTH, 32'd0));
    rows.push_back(checked_row(1'b1, 1'b1, 16'd1));
    repeat (3) rows.push_back(tick_row(1'b0));
    rows.push_back(cfg_row(CFG_PIN_DIGITS, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(CFG_PIN_LENGTH, 32'd8));
    rows.push_back(cfg_row(CFG_KEEP_ALIVE, 32'hFFFF));
    rows.push_back(cfg_row(CFG_FLASH, 32'hFFFF));
    rows.push_back(cfg_row(CFG_SHORT_PULSE, 32'hFFFF));
    rows.push_back(cfg_row(CFG_GAP, 32'hFF_FFFF));
    rows.push_back(cfg_row(CFG_RESEND, 32'hFF));
    rows.push_back(cfg_row(CFG_FORCE_WAIT, 32'hFFFF));
    rows.push_back(checked_row(1'b1, 1'b1, 16'hFFFF));
    rows.push_back(checked_row(1'b0, 1'b1, 16'hFFFE));
    // A write to an unused index must leave the pulse length alone.
    rows.push_back(cfg_row(CFG_UNUSED, 32'd0));
    rows.push_back(checked_row(1'b1, 1'b1, 16'hFFFF));

    prev_kind = ROW_TICK;
    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_CFG) begin
        if (prev_kind == ROW_TICK) drain_results();
        write_reg(row.index, row.data);
      end else begin
        cfg_valid <= 1'b0;
        send_tick(row.button, row.typed, row.report);
      end
      prev_kind = row.kind;
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      for (int r = 0; r < 8; r++) begin
        pick = $urandom_range(0, 19);
        case (r) inside
          CFG_PIN_DIGITS: begin
            top   = 32'hFFFF_FFFF;
            value = $urandom;
            if (pick != 0)
              for (int n = 0; n < 8; n++)
                value[4*n +: 4] = ($urandom_range(0, 7) == 0) ?
                                  4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
          end
          CFG_PIN_LENGTH: begin
            top   = 32'hF;
            value = (pick < 5) ? $urandom_range(0, 15) : $urandom_range(1, 8);
          end
          CFG_KEEP_ALIVE, CFG_FORCE_WAIT: begin
            top   = 32'hFFFF;
            value = (pick == 0) ? $urandom_range(0, 65535) :
                    (pick == 1) ? 32'd0 : $urandom_range(1, 12);
          end
          CFG_FLASH, CFG_SHORT_PULSE: begin
            top   = 32'hFFFF;
            value = (pick == 0) ? $urandom_range(0, 65535) :
                    (pick == 1) ? 32'd0 : $urandom_range(1, 5);
          end
          CFG_GAP: begin
            top   = 32'hFF_FFFF;
            value = (pick == 0) ? $urandom_range(0, 32'hFF_FFFF) :
                    {8'd0, 8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                     8'($urandom_range(0, 4))};
          end
          default: begin
            top   = 32'hFF;
            value = (pick == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
          end
        endcase
        if (seg == 3) value = top;
        else if (seg == 7) value = '0;
        write_reg(r[CFG_INDEX_W-1:0], value);
      end
      write_reg(8'($urandom_range(8, 255)), $urandom);
      cfg_valid <= 1'b0;

      case (seg / 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 68; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 68; end
        default: begin send_idle_pct = 35; recv_idle_pct = 35; end
      endcase
      if (seg == 1) burst_req = 1'b1;

      for (int t = 0; t < TICKS_PER_SEGMENT; t++)
        send_tick($urandom_range(0, 29) == 0, 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
